FILE: hw/rtl/rscp_pkg.sv
// Shared types, constants and tables of the radial sine/cosine pattern core.
// Has no dependencies; every other file of the block uses it except the two channel interfaces.

package rscp_pkg;

	localparam int AddrW         = 5;
	localparam int DataW         = 32;
	localparam int CordicStages  = 16;
	localparam int AtanEntries   = 24;
	localparam int CordicGain    = 652032877;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_WAVE_AMPLITUDE = 3'd2;
	localparam logic [2:0] REG_WAVE_FREQUENCY = 3'd3;
	localparam logic [2:0] REG_CENTER_X       = 3'd4;
	localparam logic [2:0] REG_CENTER_Y       = 3'd5;
	localparam logic [2:0] REG_PHASE_OFFSET   = 3'd6;

	typedef struct packed {
		logic        [12:0] image_width;
		logic        [12:0] image_height;
		logic signed [15:0] wave_amplitude;
		logic        [15:0] wave_frequency;
		logic signed [16:0] center_x;
		logic signed [16:0] center_y;
		logic        [15:0] phase_offset;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] sine_value;
		logic signed [15:0] cosine_value;
	} wave_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] v;
		begin
			unique case (idx)
				0: v = 32'd536870912;
				1: v = 32'd316933406;
				2: v = 32'd167458907;
				3: v = 32'd85004756;
				4: v = 32'd42667331;
				5: v = 32'd21354465;
				6: v = 32'd10679838;
				7: v = 32'd5340245;
				8: v = 32'd2670163;
				9: v = 32'd1335087;
				10: v = 32'd667544;
				11: v = 32'd333772;
				12: v = 32'd166886;
				13: v = 32'd83443;
				14: v = 32'd41722;
				15: v = 32'd20861;
				16: v = 32'd10430;
				17: v = 32'd5215;
				18: v = 32'd2608;
				19: v = 32'd1304;
				20: v = 32'd652;
				21: v = 32'd326;
				22: v = 32'd163;
				23: v = 32'd81;
				default: v = 32'd0;
			endcase
			return v;
		end
	endfunction

endpackage

FILE: hw/rtl/rscp_pix_if.sv
// Pixel position channel: valid/ready handshake with row and column.
// Depends on nothing.

interface rscp_pix_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_row;
	logic [11:0] pixel_col;

	modport source (output valid, output pixel_row, output pixel_col, input ready);
	modport sink (input valid, input pixel_row, input pixel_col, output ready);
endinterface

FILE: hw/rtl/rscp_wave_if.sv
// Result channel: valid/ready handshake with sine and cosine values.
// Depends on nothing.

interface rscp_wave_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sine_value;
	logic signed [15:0] cosine_value;

	modport source (output valid, output sine_value, output cosine_value, input ready);
	modport sink (input valid, input sine_value, input cosine_value, output ready);
endinterface

FILE: hw/rtl/rscp_regs.sv
// APB-style configuration register file of the pattern core.
// Depends on rscp_pkg.

module rscp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rscp_pkg::AddrW-1:0]   paddr,
	input  logic [rscp_pkg::DataW-1:0]   pwdata,
	output logic [rscp_pkg::DataW-1:0]   prdata,
	output logic                         pready,
	output rscp_pkg::cfg_t               cfg
);

	rscp_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= 13'd128;
			cfg_q.image_height   <= 13'd128;
			cfg_q.wave_amplitude <= 16'sd256;
			cfg_q.wave_frequency <= 16'd1280;
			cfg_q.center_x       <= 17'sd0;
			cfg_q.center_y       <= 17'sd0;
			cfg_q.phase_offset   <= 16'd0;
		end else if (wr_en) begin
			unique case (idx)
				rscp_pkg::REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[12:0];
				rscp_pkg::REG_IMAGE_HEIGHT:   cfg_q.image_height   <= pwdata[12:0];
				rscp_pkg::REG_WAVE_AMPLITUDE: cfg_q.wave_amplitude <= pwdata[15:0];
				rscp_pkg::REG_WAVE_FREQUENCY: cfg_q.wave_frequency <= pwdata[15:0];
				rscp_pkg::REG_CENTER_X:       cfg_q.center_x       <= pwdata[16:0];
				rscp_pkg::REG_CENTER_Y:       cfg_q.center_y       <= pwdata[16:0];
				rscp_pkg::REG_PHASE_OFFSET:   cfg_q.phase_offset   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rscp_pkg::REG_IMAGE_WIDTH:    prdata = {19'd0, cfg_q.image_width};
			rscp_pkg::REG_IMAGE_HEIGHT:   prdata = {19'd0, cfg_q.image_height};
			rscp_pkg::REG_WAVE_AMPLITUDE: prdata = {{16{cfg_q.wave_amplitude[15]}},
				cfg_q.wave_amplitude};
			rscp_pkg::REG_WAVE_FREQUENCY: prdata = {16'd0, cfg_q.wave_frequency};
			rscp_pkg::REG_CENTER_X:       prdata = {{15{cfg_q.center_x[16]}}, cfg_q.center_x};
			rscp_pkg::REG_CENTER_Y:       prdata = {{15{cfg_q.center_y[16]}}, cfg_q.center_y};
			rscp_pkg::REG_PHASE_OFFSET:   prdata = {16'd0, cfg_q.phase_offset};
			default:                      prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/rscp_dist.sv
// Distance pipeline: centred offsets, squares, and a two-bits-per-stage square root.
// Depends on rscp_pkg.

module rscp_dist (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [11:0]    pixel_row,
	input  logic [11:0]    pixel_col,
	input  rscp_pkg::cfg_t cfg,
	output logic           out_valid,
	output logic [21:0]    r8
);

	localparam int SqStages = 11;

	typedef struct packed {
		logic [23:0] rem;
		logic [21:0] root;
	} sq_t;

	function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
		logic [25:0] t;
		logic [25:0] trial;
		sq_t         nxt;
		begin
			t     = {cur.rem, pair};
			trial = {2'b00, cur.root, 2'b01};
			if (t >= trial) begin
				nxt.rem  = 24'(t - trial);
				nxt.root = {cur.root[20:0], 1'b1};
			end else begin
				nxt.rem  = t[23:0];
				nxt.root = {cur.root[20:0], 1'b0};
			end
			return nxt;
		end
	endfunction

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [13:0] x_s1, y_s1;
	logic signed [18:0] dx_s2, dy_s2;
	logic        [33:0] dxsq_s3, dysq_s3;
	logic        [34:0] r2_s4;
	logic signed [37:0] dxsq, dysq;

	logic        sq_v_s   [SqStages+1];
	logic [43:0] sq_rad_s [SqStages+1];
	sq_t         sq_st_s  [SqStages+1];

	assign dxsq = dx_s2 * dx_s2;
	assign dysq = dy_s2 * dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= $signed({2'b00, pixel_col}) - $signed({2'b00, cfg.image_width[12:1]});
			y_s1    <= $signed({2'b00, cfg.image_height[12:1]}) - $signed({2'b00, pixel_row});
			dx_s2   <= {{1{x_s1[13]}}, x_s1, 4'b0000}
				- {{2{cfg.center_x[16]}}, cfg.center_x};
			dy_s2   <= {{1{y_s1[13]}}, y_s1, 4'b0000}
				- {{2{cfg.center_y[16]}}, cfg.center_y};
			dxsq_s3 <= dxsq[33:0];
			dysq_s3 <= dysq[33:0];
			r2_s4   <= {1'b0, dxsq_s3} + {1'b0, dysq_s3};
		end
	end

	// radicand is r2 * 256, padded to an even width
	assign sq_v_s[0]   = v_s4;
	assign sq_rad_s[0] = {1'b0, r2_s4, 8'd0};
	assign sq_st_s[0]  = '0;

	for (genvar k = 0; k < SqStages; k++) begin : g_sqrt
		sq_t mid;
		sq_t nxt;
		assign mid = sqrt_step(sq_st_s[k], sq_rad_s[k][43:42]);
		assign nxt = sqrt_step(mid, sq_rad_s[k][41:40]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[k+1] <= {sq_rad_s[k][39:0], 4'd0};
				sq_st_s[k+1]  <= nxt;
			end
		end
	end

	assign out_valid = sq_v_s[SqStages];
	assign r8        = sq_st_s[SqStages].root;

endmodule

FILE: hw/rtl/rscp_phase.sv
// Phase pipeline: frequency times distance, long division by the width, offset add.
// Depends on rscp_pkg.

module rscp_phase (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [21:0]    r8,
	input  rscp_pkg::cfg_t cfg,
	output logic           out_valid,
	output logic [31:0]    phase
);

	localparam int BitsPerStage = 4;
	localparam int NumW         = 56;
	localparam int DivStages    = NumW / BitsPerStage;

	typedef struct packed {
		logic [12:0] rem;
		logic [31:0] quo;
	} dv_t;

	logic        [12:0] divisor;
	logic               v_s1;
	logic        [37:0] prod_s1;
	logic               ph_v_q;
	logic        [31:0] ph_q;

	logic        dv_v_s   [DivStages+1];
	logic [55:0] dv_num_s [DivStages+1];
	dv_t         dv_st_s  [DivStages+1];

	// a zero width divides as one
	assign divisor = (cfg.image_width == 13'd0) ? 13'd1 : cfg.image_width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ph_v_q <= 1'b0;
		end else if (en) begin
			v_s1   <= in_valid;
			ph_v_q <= dv_v_s[DivStages];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {22'd0, cfg.wave_frequency} * {16'd0, r8};
			ph_q    <= dv_st_s[DivStages].quo + {cfg.phase_offset, 16'd0};
		end
	end

	assign dv_v_s[0]   = v_s1;
	assign dv_num_s[0] = {2'b00, prod_s1, 16'd0};
	assign dv_st_s[0]  = '0;

	for (genvar k = 0; k < DivStages; k++) begin : g_div
		dv_t nxt;

		always_comb begin
			logic [13:0] t;
			nxt = dv_st_s[k];
			for (int b = 0; b < BitsPerStage; b++) begin
				t = {nxt.rem, dv_num_s[k][NumW-1-b]};
				if (t >= {1'b0, divisor}) begin
					nxt.rem = 13'(t - {1'b0, divisor});
					nxt.quo = {nxt.quo[30:0], 1'b1};
				end else begin
					nxt.rem = t[12:0];
					nxt.quo = {nxt.quo[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_num_s[k+1] <= {dv_num_s[k][NumW-BitsPerStage-1:0], {BitsPerStage{1'b0}}};
				dv_st_s[k+1]  <= nxt;
			end
		end
	end

	assign out_valid = ph_v_q;
	assign phase     = ph_q;

endmodule

FILE: hw/rtl/rscp_cordic.sv
// Rotation CORDIC on the residual phase, quadrant fold, amplitude scaling and saturation.
// Depends on rscp_pkg.

module rscp_cordic #(
	parameter int CORDIC_STAGES = rscp_pkg::CordicStages
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [31:0]     phase,
	input  rscp_pkg::cfg_t  cfg,
	output logic            out_valid,
	output rscp_pkg::wave_t wave
);

	typedef struct packed {
		logic [1:0]         quad;
		logic signed [33:0] cx;
		logic signed [33:0] cy;
		logic signed [33:0] z;
	} rot_t;

	logic        [31:0] ph_bias;
	logic        [1:0]  quad;
	logic        [31:0] zres;

	logic        cr_v_s  [CORDIC_STAGES+1];
	rot_t        cr_st_s [CORDIC_STAGES+1];

	logic               v_sel, v_mul, v_rnd;
	logic signed [31:0] sin_sel, cos_sel;
	logic signed [47:0] sin_mul, cos_mul;
	logic signed [15:0] sin_rnd, cos_rnd;
	logic signed [33:0] fs, fc;

	function automatic logic signed [15:0] round_sat(input logic signed [47:0] p);
		logic signed [48:0] t;
		logic signed [18:0] q;
		begin
			t = {p[47], p} + 49'sd536870912;
			q = 19'(t >>> 30);
			if (q > 19'sd32767) begin
				return 16'sd32767;
			end else if (q < -19'sd32768) begin
				return -16'sd32768;
			end else begin
				return q[15:0];
			end
		end
	endfunction

	// nearest quarter turn and residual within one eighth of a turn
	assign ph_bias = phase + 32'h2000_0000;
	assign quad    = ph_bias[31:30];
	assign zres    = phase - {quad, 30'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_v_s[0] <= 1'b0;
		end else if (en) begin
			cr_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_st_s[0].quad <= quad;
			cr_st_s[0].cx   <= 34'(rscp_pkg::CordicGain);
			cr_st_s[0].cy   <= '0;
			cr_st_s[0].z    <= {{2{zres[31]}}, zres};
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		logic signed [33:0] xs, ys, at;
		assign xs = cr_st_s[i].cx >>> i;
		assign ys = cr_st_s[i].cy >>> i;
		assign at = $signed({2'b00, rscp_pkg::atan_turn(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_v_s[i+1] <= 1'b0;
			end else if (en) begin
				cr_v_s[i+1] <= cr_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cr_st_s[i+1].quad <= cr_st_s[i].quad;
				if (!cr_st_s[i].z[33]) begin
					cr_st_s[i+1].cx <= cr_st_s[i].cx - ys;
					cr_st_s[i+1].cy <= cr_st_s[i].cy + xs;
					cr_st_s[i+1].z  <= cr_st_s[i].z - at;
				end else begin
					cr_st_s[i+1].cx <= cr_st_s[i].cx + ys;
					cr_st_s[i+1].cy <= cr_st_s[i].cy - xs;
					cr_st_s[i+1].z  <= cr_st_s[i].z + at;
				end
			end
		end
	end

	// apply the quarter turn exactly
	always_comb begin
		unique case (cr_st_s[CORDIC_STAGES].quad)
			2'd0: begin
				fc = cr_st_s[CORDIC_STAGES].cx;
				fs = cr_st_s[CORDIC_STAGES].cy;
			end
			2'd1: begin
				fc = -cr_st_s[CORDIC_STAGES].cy;
				fs = cr_st_s[CORDIC_STAGES].cx;
			end
			2'd2: begin
				fc = -cr_st_s[CORDIC_STAGES].cx;
				fs = -cr_st_s[CORDIC_STAGES].cy;
			end
			default: begin
				fc = cr_st_s[CORDIC_STAGES].cy;
				fs = -cr_st_s[CORDIC_STAGES].cx;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sel <= 1'b0;
			v_mul <= 1'b0;
			v_rnd <= 1'b0;
		end else if (en) begin
			v_sel <= cr_v_s[CORDIC_STAGES];
			v_mul <= v_sel;
			v_rnd <= v_mul;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_sel <= fs[31:0];
			cos_sel <= fc[31:0];
			sin_mul <= cfg.wave_amplitude * sin_sel;
			cos_mul <= cfg.wave_amplitude * cos_sel;
			sin_rnd <= round_sat(sin_mul);
			cos_rnd <= round_sat(cos_mul);
		end
	end

	assign out_valid         = v_rnd;
	assign wave.sine_value   = sin_rnd;
	assign wave.cosine_value = cos_rnd;

endmodule

FILE: hw/rtl/radial_sine_cosine_pattern_core.sv
// Top level of the radial sine/cosine pattern core: registers, pipelines, output skid.
// Depends on rscp_pkg, rscp_pix_if, rscp_wave_if and the rscp_* modules.
//
//  channel | direction | handshake     | payload
//  --------+-----------+---------------+--------------------------------------
//  pixel   | in        | valid/ready   | pixel_row[11:0], pixel_col[11:0]
//  wave    | out       | valid/ready   | sine_value[15:0], cosine_value[15:0]
//  apb     | in        | psel/penable  | paddr[4:0], pwdata/prdata[31:0]
//
// One pixel per clock while the skid buffer is empty. The pipeline runs through the 11-stage
// square root, the 14-stage divider and one stage per CORDIC rotation.
// Reset clears all valid bits and loads the register defaults.
// A stalled result parks in a one-entry skid buffer; the pipeline and pixel.ready
// hold only while that buffer is full.

module radial_sine_cosine_pattern_core #(
	parameter int CORDIC_STAGES = rscp_pkg::CordicStages
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rscp_pix_if.sink                   pixel,
	rscp_wave_if.source                wave,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rscp_pkg::AddrW-1:0] paddr,
	input  logic [rscp_pkg::DataW-1:0] pwdata,
	output logic [rscp_pkg::DataW-1:0] prdata,
	output logic                       pready
);

	rscp_pkg::cfg_t  cfg;
	logic            en;
	logic            dist_v, ph_v, res_v;
	logic [21:0]     r8;
	logic [31:0]     phase;
	rscp_pkg::wave_t res;

	logic            out_v_q, skid_v_q;
	rscp_pkg::wave_t out_q, skid_q;
	logic            out_load;

	assign en          = ~skid_v_q;
	assign pixel.ready = en;

	rscp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rscp_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pixel.valid),
		.pixel_row (pixel.pixel_row),
		.pixel_col (pixel.pixel_col),
		.cfg       (cfg),
		.out_valid (dist_v),
		.r8        (r8)
	);

	rscp_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dist_v),
		.r8        (r8),
		.cfg       (cfg),
		.out_valid (ph_v),
		.phase     (phase)
	);

	rscp_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ph_v),
		.phase     (phase),
		.cfg       (cfg),
		.out_valid (res_v),
		.wave      (res)
	);

	assign out_load = ~out_v_q | wave.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_load) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= res_v;
			end
		end else if (en && res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (en && res_v) begin
			// park the transfer that arrives while the output is held
			skid_q <= res;
		end
	end

	assign wave.valid        = out_v_q;
	assign wave.sine_value   = out_q.sine_value;
	assign wave.cosine_value = out_q.cosine_value;

endmodule

FILE: tb/testbench.sv
// Self-checking bench for radial_sine_cosine_pattern_core: random pixel positions
// under changing register settings, results checked against a bit-true predictor.
// Depends on rscp_pkg, rscp_pix_if, rscp_wave_if and the core itself.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 36 + rscp_pkg::CordicStages;
	localparam int WDOG_MAX  = 3000;
	localparam int HOLD_LEN  = 400;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
	} pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [rscp_pkg::AddrW-1:0] paddr = '0;
	logic [rscp_pkg::DataW-1:0] pwdata = '0;
	logic [rscp_pkg::DataW-1:0] prdata;
	logic pready;

	rscp_pix_if  pixel ();
	rscp_wave_if wave ();

	radial_sine_cosine_pattern_core uut (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .wave(wave),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rscp_pkg::cfg_t  cfg;
	pos_t            pos_pending[$];
	rscp_pkg::wave_t wave_expected[$];
	int    send_idle_pct = 0;
	int    stall_pct = 0;
	int    errors = 0;
	int    idle_cycles = 0;
	int    hold_left = 0;
	bit    hold_req = 0;
	bit    hold_done = 0;
	logic  pix_taken = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic signed [15:0] scale_sat(input longint unit);
		longint p;
		p = (longint'(cfg.wave_amplitude) * unit + (longint'(1) << 29)) >>> 30;
		if (p > 32767)
			return 16'sh7fff;
		if (p < -32768)
			return 16'sh8000;
		return p[15:0];
	endfunction

	function automatic rscp_pkg::wave_t radial_wave(input logic [11:0] row,
			input logic [11:0] col);
		longint x, y, dx, dy, z, cx, cy, xs, ys, c, s;
		longint unsigned r2, r8, dv, quot;
		logic [31:0] ph, qs;
		logic [1:0] quad;
		rscp_pkg::wave_t w;
		x = longint'(col) - longint'(cfg.image_width / 2);
		y = longint'(cfg.image_height / 2) - longint'(row);
		dx = x * 16 - longint'(cfg.center_x);
		dy = y * 16 - longint'(cfg.center_y);
		r2 = longint'(dx * dx + dy * dy);
		r8 = int_sqrt(r2 * 256);
		dv = (cfg.image_width == 0) ? 1 : longint'(cfg.image_width);
		quot = (longint'(cfg.wave_frequency) * r8 * 65536) / dv;
		ph = quot[31:0] + {cfg.phase_offset, 16'h0000};
		qs = ph + 32'h2000_0000;
		quad = qs[31:30];
		z = longint'(ph) - (longint'(quad) << 30);
		if (z >= (longint'(1) << 31))
			z -= longint'(1) << 32;
		cx = rscp_pkg::CordicGain;
		cy = 0;
		for (int i = 0; i < rscp_pkg::CordicStages; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (z >= 0) begin
				cx -= ys;
				cy += xs;
				z -= longint'(rscp_pkg::atan_turn(i));
			end else begin
				cx += ys;
				cy -= xs;
				z += longint'(rscp_pkg::atan_turn(i));
			end
		end
		case (quad)
			2'd0: begin c = cx; s = cy; end
			2'd1: begin c = -cy; s = cx; end
			2'd2: begin c = -cx; s = -cy; end
			default: begin c = cy; s = -cx; end
		endcase
		w.sine_value = scale_sat(s);
		w.cosine_value = scale_sat(c);
		return w;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			rscp_pkg::REG_IMAGE_WIDTH:    cfg.image_width = val[12:0];
			rscp_pkg::REG_IMAGE_HEIGHT:   cfg.image_height = val[12:0];
			rscp_pkg::REG_WAVE_AMPLITUDE: cfg.wave_amplitude = val[15:0];
			rscp_pkg::REG_WAVE_FREQUENCY: cfg.wave_frequency = val[15:0];
			rscp_pkg::REG_CENTER_X:       cfg.center_x = val[16:0];
			rscp_pkg::REG_CENTER_Y:       cfg.center_y = val[16:0];
			rscp_pkg::REG_PHASE_OFFSET:   cfg.phase_offset = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_settings(input logic [12:0] w, input logic [12:0] h,
			input logic [15:0] amp, input logic [15:0] freq, input logic [16:0] cx,
			input logic [16:0] cy, input logic [15:0] po);
		reg_write(rscp_pkg::REG_IMAGE_WIDTH, 32'(w));
		reg_write(rscp_pkg::REG_IMAGE_HEIGHT, 32'(h));
		reg_write(rscp_pkg::REG_WAVE_AMPLITUDE, 32'(amp));
		reg_write(rscp_pkg::REG_WAVE_FREQUENCY, 32'(freq));
		reg_write(rscp_pkg::REG_CENTER_X, 32'(cx));
		reg_write(rscp_pkg::REG_CENTER_Y, 32'(cy));
		reg_write(rscp_pkg::REG_PHASE_OFFSET, 32'(po));
	endtask

	task automatic drain;
		do @(posedge clk);
		while (pos_pending.size() != 0 || pixel.valid || wave_expected.size() != 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic add_random_positions(input int count);
		pos_t p;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 30 && cfg.image_width != 0 && cfg.image_height != 0) begin
				p.row = 12'($urandom_range(int'(cfg.image_height) - 1 > 4095 ? 4095
					: int'(cfg.image_height) - 1));
				p.col = 12'($urandom_range(int'(cfg.image_width) - 1 > 4095 ? 4095
					: int'(cfg.image_width) - 1));
			end else begin
				p.row = 12'($urandom);
				p.col = 12'($urandom);
			end
			pos_pending.push_back(p);
		end
	endtask

	// sender: hold the item until it is transferred
	always @(negedge clk) begin
		pos_t p;
		if (arst_n && (!pixel.valid || pix_taken)) begin
			if (pos_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				p = pos_pending.pop_front();
				pixel.valid <= 1'b1;
				pixel.pixel_row <= p.row;
				pixel.pixel_col <= p.col;
			end else begin
				pixel.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		pix_taken <= pixel.valid && pixel.ready;
		if (pixel.valid && pixel.ready)
			wave_expected.push_back(radial_wave(pixel.pixel_row, pixel.pixel_col));
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			wave.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			wave.ready <= 1'b0;
		end else begin
			wave.ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		rscp_pkg::wave_t got, exp_w;
		if (wave.valid && wave.ready) begin
			got.sine_value = wave.sine_value;
			got.cosine_value = wave.cosine_value;
			if (wave_expected.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				exp_w = wave_expected.pop_front();
				if (got.sine_value !== exp_w.sine_value)
					$display("%0t: sine expected %0d got %0d", $time,
						exp_w.sine_value, got.sine_value);
				if (got.cosine_value !== exp_w.cosine_value)
					$display("%0t: cosine expected %0d got %0d", $time,
						exp_w.cosine_value, got.cosine_value);
				if (got !== exp_w)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel.valid && pixel.ready) || (wave.valid && wave.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		pixel.valid = 1'b0;
		pixel.pixel_row = '0;
		pixel.pixel_col = '0;
		wave.ready = 1'b0;
		cfg.image_width = 13'd128;
		cfg.image_height = 13'd128;
		cfg.wave_amplitude = 16'sd256;
		cfg.wave_frequency = 16'd1280;
		cfg.center_x = '0;
		cfg.center_y = '0;
		cfg.phase_offset = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: corners, centre, position outside the image
		pos_pending.push_back('{12'd0, 12'd0});
		pos_pending.push_back('{12'd4095, 12'd4095});
		pos_pending.push_back('{12'd0, 12'd4095});
		pos_pending.push_back('{12'd4095, 12'd0});
		pos_pending.push_back('{12'd64, 12'd64});
		pos_pending.push_back('{12'd64, 12'd200});
		pos_pending.push_back('{12'd127, 12'd127});
		drain();

		// zero width, largest height, extreme amplitude, frequency and centre
		load_settings(13'd0, 13'd8191, 16'h8000, 16'hffff, 17'h10000, 17'h0ffff, 16'hffff);
		pos_pending.push_back('{12'd0, 12'd0});
		pos_pending.push_back('{12'd4095, 12'd4095});
		pos_pending.push_back('{12'd2048, 12'd1});
		drain();

		// zero frequency with most negative amplitude saturates the cosine
		load_settings(13'd4096, 13'd4096, 16'h8000, 16'd0, 17'd0, 17'd0, 16'd0);
		pos_pending.push_back('{12'd2048, 12'd2048});
		pos_pending.push_back('{12'd0, 12'd4095});
		drain();
		reg_write(rscp_pkg::REG_PHASE_OFFSET, 32'h4000);
		pos_pending.push_back('{12'd2048, 12'd2048});
		drain();
		load_settings(13'd8191, 13'd0, 16'h7fff, 16'd256, 17'h1ffff, 17'd1, 16'hc000);
		pos_pending.push_back('{12'd0, 12'd0});
		pos_pending.push_back('{12'd4095, 12'd4095});
		drain();
		load_settings(13'd1, 13'd1, 16'h7fff, 16'hffff, 17'd0, 17'd0, 16'h2000);
		pos_pending.push_back('{12'd0, 12'd0});
		pos_pending.push_back('{12'd0, 12'd1});
		pos_pending.push_back('{12'd4095, 12'd4095});
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 61 : 18) : 0;
			stall_pct = (ph % 4 == 2) ? 61 : (ph % 4 == 3 ? 18 : 0);
			if (ph % 3 == 0)
				load_settings(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
					16'($urandom), 16'($urandom), 17'($urandom), 17'($urandom),
					16'($urandom));
			else if (ph % 3 == 1)
				load_settings(13'($urandom_range(1, 256)), 13'($urandom_range(1, 256)),
					16'($urandom), 16'($urandom_range(0, 4096)),
					17'($urandom_range(0, 4095) - 2048),
					17'($urandom_range(0, 4095) - 2048), 16'($urandom));
			else
				load_settings(13'($urandom), 13'($urandom), 16'($urandom), 16'($urandom),
					17'($urandom), 17'($urandom), 16'($urandom));
			if (ph == 4)
				hold_req = 1'b1;
			add_random_positions(125);
			drain();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/rscp_pkg.sv
hw/rtl/rscp_pix_if.sv
hw/rtl/rscp_wave_if.sv
hw/rtl/rscp_regs.sv
hw/rtl/rscp_dist.sv
hw/rtl/rscp_phase.sv
hw/rtl/rscp_cordic.sv
hw/rtl/radial_sine_cosine_pattern_core.sv
tb/testbench.sv
